[src/bux_pkg.sv]
// Shared types and constants for the byte unstuffing decoder with XOR check.
`timescale 1ns / 1ps
package bux_pkg;

   // Register indexes on the configuration channel
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] REG_ESCAPE_PREFIX = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CODE_FOR_FE   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CODE_FOR_FD   = 2'd2;

   localparam logic [7:0] ESCAPE_PREFIX_RESET = 8'hFD;
   localparam logic [7:0] CODE_FOR_FE_RESET   = 8'h02;
   localparam logic [7:0] CODE_FOR_FD_RESET   = 8'h01;

   localparam logic [7:0] DECODED_FE = 8'hFE;
   localparam logic [7:0] DECODED_FD = 8'hFD;
   localparam logic [7:0] COUNT_MAX  = 8'hFF;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_XOR_FAIL   = 2'd1;
   localparam logic [1:0] STATUS_BAD_ESCAPE = 2'd2;

   typedef struct packed {
      logic [7:0] wire_byte;
      logic       frame_end;
   } req_payload_type;

   typedef struct packed {
      logic       data_valid;
      logic [7:0] data_byte;
      logic       frame_done;
      logic [1:0] frame_status;
      logic [7:0] decoded_length;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_INDEX_W-1:0] index;
      logic [7:0]             data;
   } csr_payload_type;

   typedef struct packed {
      logic [7:0] escape_prefix;
      logic [7:0] code_for_fe;
      logic [7:0] code_for_fd;
   } cfg_type;

   typedef struct packed {
      logic            emit;
      rsp_payload_type result;
   } dec_out_type;

endpackage

[src/bux_stream_if.sv]
// Valid/ready channel interface carrying one payload per transfer.
`timescale 1ns / 1ps
interface bux_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[src/byte_unstuff_xor_check.sv]
// Top level of the byte unstuffing decoder with running XOR frame check.
// A byte taken on req_ch is held in the input register, then its result is loaded into the result register on rsp_ch.
// Throughput: one byte per cycle; req_ch stalls only while the result register is full.
// Reset: synchronous; clears frame state and restores the escape and code registers.
`timescale 1ns / 1ps
module byte_unstuff_xor_check
   import bux_pkg::*;
(
   input logic       clock,
   input logic       reset,
   bux_stream_if.sink   req_ch,
   bux_stream_if.source rsp_ch,
   bux_stream_if.sink   csr_ch
);

   cfg_type         cfg_ff, cfg_in;
   logic            in_valid_ff, in_valid_in;
   req_payload_type in_item_ff, in_item_in;
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_item_ff, out_item_in;

   logic        advance;
   logic        req_fire;
   dec_out_type dec_out;

   // The held byte moves on whenever the result register is free or being emptied.
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_fire = req_ch.valid && req_ch.ready;

   assign req_ch.ready   = !in_valid_ff || advance;
   assign csr_ch.ready   = 1'b1;
   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.payload = out_item_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.payload.index)
            REG_ESCAPE_PREFIX: cfg_in.escape_prefix = csr_ch.payload.data;
            REG_CODE_FOR_FE:   cfg_in.code_for_fe   = csr_ch.payload.data;
            REG_CODE_FOR_FD:   cfg_in.code_for_fd   = csr_ch.payload.data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_item_in  = req_ch.payload;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (advance) begin
         out_valid_in = dec_out.emit;
         out_item_in  = dec_out.result;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.escape_prefix <= ESCAPE_PREFIX_RESET;
         cfg_ff.code_for_fe   <= CODE_FOR_FE_RESET;
         cfg_ff.code_for_fd   <= CODE_FOR_FD_RESET;
         in_valid_ff          <= 1'b0;
         out_valid_ff         <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   bux_decoder u_decoder (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .item    (in_item_ff),
      .advance (advance),
      .dec_out (dec_out)
   );

endmodule

[src/bux_decoder.sv]
// Per-frame unstuffing state, XOR accumulator and result formation.
`timescale 1ns / 1ps
module bux_decoder
   import bux_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  req_payload_type item,
   input  logic            advance,
   output dec_out_type     dec_out
);

   logic       pending_ff, pending_in;
   logic       bad_ff, bad_in;
   logic [7:0] acc_ff, acc_in;
   logic [7:0] count_ff, count_in;

   logic       have_data;
   logic [7:0] data;
   logic       pending_next;
   logic       bad_next;
   logic [7:0] acc_next;
   logic [7:0] count_next;

   always_comb begin
      have_data    = 1'b0;
      data         = 8'h00;
      pending_next = pending_ff;
      bad_next     = bad_ff;
      acc_next     = acc_ff ^ item.wire_byte;

      // Once a bad escape is seen, the rest of the frame is only XORed.
      if (!bad_ff) begin
         if (pending_ff) begin
            pending_next = 1'b0;
            priority if (item.wire_byte == cfg.code_for_fe) begin
               have_data = 1'b1;
               data      = DECODED_FE;
            end else if (item.wire_byte == cfg.code_for_fd) begin
               have_data = 1'b1;
               data      = DECODED_FD;
            end else begin
               bad_next = 1'b1;
            end
         end else if (item.wire_byte == cfg.escape_prefix) begin
            if (item.frame_end) begin
               bad_next = 1'b1;
            end else begin
               pending_next = 1'b1;
            end
         end else begin
            have_data = 1'b1;
            data      = item.wire_byte;
         end
      end

      count_next = count_ff;
      if (have_data && (count_ff != COUNT_MAX)) begin
         count_next = count_ff + 8'd1;
      end
   end

   always_comb begin
      dec_out.emit              = have_data || item.frame_end;
      dec_out.result.data_valid = have_data;
      dec_out.result.data_byte  = data;
      dec_out.result.frame_done = item.frame_end;
      dec_out.result.frame_status   = STATUS_OK;
      dec_out.result.decoded_length = 8'h00;
      if (item.frame_end) begin
         priority if (bad_next) begin
            dec_out.result.frame_status = STATUS_BAD_ESCAPE;
         end else if (acc_next != 8'h00) begin
            dec_out.result.frame_status = STATUS_XOR_FAIL;
         end else begin
            dec_out.result.frame_status = STATUS_OK;
         end
         dec_out.result.decoded_length = count_next;
      end
   end

   always_comb begin
      pending_in = pending_ff;
      bad_in     = bad_ff;
      acc_in     = acc_ff;
      count_in   = count_ff;
      if (advance) begin
         if (item.frame_end) begin
            pending_in = 1'b0;
            bad_in     = 1'b0;
            acc_in     = 8'h00;
            count_in   = 8'h00;
         end else begin
            pending_in = pending_next;
            bad_in     = bad_next;
            acc_in     = acc_next;
            count_in   = count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         bad_ff     <= 1'b0;
         acc_ff     <= 8'h00;
         count_ff   <= 8'h00;
      end else begin
         pending_ff <= pending_in;
         bad_ff     <= bad_in;
         acc_ff     <= acc_in;
         count_ff   <= count_in;
      end
   end

endmodule

[src/bux_checker.sv]
// Port-level checks on the result channel, bound to the top level.
`timescale 1ns / 1ps
module bux_checker
   import bux_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);

   // Every result carries a decoded byte, closes a frame, or both.
   a_result_has_content: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.data_valid || rsp_payload.frame_done))
      else $error("result transfer with neither a byte nor a frame close");

   // Status and length are zero unless the result closes the frame.
   a_frame_fields_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.frame_done) |->
         (rsp_payload.frame_status == STATUS_OK && rsp_payload.decoded_length == 8'h00))
      else $error("frame status or length set on a result that does not close a frame");

   // A missing byte reads as zero, and the status code is always a known one.
   a_payload_codes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_payload.data_valid || rsp_payload.data_byte == 8'h00) &&
         (rsp_payload.frame_status == STATUS_OK ||
          rsp_payload.frame_status == STATUS_XOR_FAIL ||
          rsp_payload.frame_status == STATUS_BAD_ESCAPE)))
      else $error("inconsistent result payload");

   // A stalled result stays offered and unchanged.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("result changed or withdrawn while stalled");

endmodule

bind byte_unstuff_xor_check bux_checker u_bux_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_payload (rsp_ch.payload)
);

[tb/sv/byte_unstuff_xor_check_test.sv]
// Self-checking testbench for the byte unstuffing decoder with XOR frame check.
`timescale 1ns / 1ps
module byte_unstuff_xor_check_test;
   import bux_pkg::*;

   typedef logic [7:0] wire_frame_type[$];

   // Index 3 decodes to no register, so a write to it must change nothing.
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int CYCLE_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bux_stream_if #(.payload_type(req_payload_type)) req_ch ();
   bux_stream_if #(.payload_type(rsp_payload_type)) rsp_ch ();
   bux_stream_if #(.payload_type(csr_payload_type)) csr_ch ();

   byte_unstuff_xor_check dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #1 clock = ~clock;

   // Register values as the decoder should currently hold them.
   cfg_type cfg_shadow = '{ESCAPE_PREFIX_RESET, CODE_FOR_FE_RESET, CODE_FOR_FD_RESET};

   // Frame state of the predicted decoder.
   logic       esc_pending = 1'b0;
   logic [7:0] xor_acc     = '0;
   logic [7:0] byte_count  = '0;
   logic       bad_seen    = 1'b0;

   req_payload_type wire_bytes_queue[$];
   rsp_payload_type expected_results[$];
   int items_queued = 0;
   int error_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_off_go = 1'b0;
   logic rsp_hold = 1'b0;

   function automatic void decode_wire_byte(input req_payload_type item);
      rsp_payload_type res;
      logic            have_data;
      logic [7:0]      data;
      have_data = 1'b0;
      data = '0;
      res = '0;
      xor_acc ^= item.wire_byte;
      if (!bad_seen) begin
         if (esc_pending) begin
            esc_pending = 1'b0;
            if (item.wire_byte == cfg_shadow.code_for_fe) begin
               have_data = 1'b1;
               data = DECODED_FE;
            end else if (item.wire_byte == cfg_shadow.code_for_fd) begin
               have_data = 1'b1;
               data = DECODED_FD;
            end else begin
               bad_seen = 1'b1;
            end
         end else if (item.wire_byte == cfg_shadow.escape_prefix) begin
            // A prefix with nothing after it in the frame cannot complete an escape.
            if (item.frame_end) bad_seen = 1'b1;
            else esc_pending = 1'b1;
         end else begin
            have_data = 1'b1;
            data = item.wire_byte;
         end
      end
      if (have_data && byte_count != COUNT_MAX) byte_count++;
      if (have_data || item.frame_end) begin
         res.data_valid = have_data;
         res.data_byte = data;
         res.frame_done = item.frame_end;
         if (item.frame_end) begin
            if (bad_seen) res.frame_status = STATUS_BAD_ESCAPE;
            else if (xor_acc != 8'h00) res.frame_status = STATUS_XOR_FAIL;
            else res.frame_status = STATUS_OK;
            res.decoded_length = byte_count;
            esc_pending = 1'b0;
            xor_acc = '0;
            byte_count = '0;
            bad_seen = 1'b0;
         end
         expected_results.push_back(res);
      end
   endfunction

   function automatic void check_field(input string label, input logic [7:0] want,
                                       input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
         error_count++;
      end
   endfunction

   // Driver: offers the next queued byte once the previous transfer has completed.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) decode_wire_byte(req_ch.payload);
         if (!req_ch.valid || req_ch.ready) begin
            if (wire_bytes_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_ch.valid <= 1'b1;
               req_ch.payload <= wire_bytes_queue.pop_front();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
   end

   // Monitor: every result transfer is matched against the oldest prediction.
   always @(posedge clock) begin : result_monitor
      rsp_payload_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p", $time, rsp_ch.payload);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("data_valid", {7'b0, want.data_valid},
                        {7'b0, rsp_ch.payload.data_valid});
            check_field("data_byte", want.data_byte, rsp_ch.payload.data_byte);
            check_field("frame_done", {7'b0, want.frame_done},
                        {7'b0, rsp_ch.payload.frame_done});
            check_field("frame_status", {6'b0, want.frame_status},
                        {6'b0, rsp_ch.payload.frame_status});
            check_field("decoded_length", want.decoded_length, rsp_ch.payload.decoded_length);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("byte_unstuff_xor_check_test failed");
         $finish;
      end
   end

   // The receiver stalls for a long stretch so that the decoder backs up onto its input.
   initial begin
      wait (hold_off_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (b == cfg_shadow.escape_prefix);
      return b;
   endfunction

   function automatic logic [7:0] bad_code();
      logic [7:0] b;
      do b = 8'($urandom_range(255));
      while (b == cfg_shadow.code_for_fe || b == cfg_shadow.code_for_fd);
      return b;
   endfunction

   // Well-formed frame of the given number of data units plus closing bytes that bring its XOR to zero.
   function automatic wire_frame_type clean_frame(input int units);
      wire_frame_type frame;
      logic [7:0]     sum;
      logic [7:0]     pad;
      sum = '0;
      repeat (units) begin
         if ($urandom_range(99) < 20) begin
            frame.push_back(cfg_shadow.escape_prefix);
            frame.push_back($urandom_range(1) ? cfg_shadow.code_for_fe : cfg_shadow.code_for_fd);
         end else begin
            frame.push_back(plain_byte());
         end
      end
      foreach (frame[i]) sum ^= frame[i];
      // A closing byte equal to the prefix would be read as an escape, so shift it first.
      if (sum == cfg_shadow.escape_prefix) begin
         do pad = plain_byte(); while (pad == 8'h00);
         frame.push_back(pad);
         sum ^= pad;
      end
      frame.push_back(sum);
      return frame;
   endfunction

   task automatic queue_item(input logic [7:0] b, input logic last);
      req_payload_type item;
      item.wire_byte = b;
      item.frame_end = last;
      wire_bytes_queue.push_back(item);
      items_queued++;
   endtask

   task automatic queue_frame(input wire_frame_type frame);
      foreach (frame[i]) queue_item(frame[i], i == frame.size() - 1);
   endtask

   task automatic queue_random_traffic(input int n_items);
      wire_frame_type frame;
      int             start;
      int             kind;
      start = items_queued;
      while (items_queued - start < n_items) begin
         kind = $urandom_range(99);
         if (kind < 88) begin
            frame = clean_frame($urandom_range(99) < 90 ? $urandom_range(1, 8)
                                                        : $urandom_range(9, 40));
            if (kind < 10) begin
               frame[frame.size() - 1] ^= 8'h01 << $urandom_range(7);
            end else if (kind < 20) begin
               frame.push_back(cfg_shadow.escape_prefix);
               frame.push_back(bad_code());
               repeat ($urandom_range(3)) frame.push_back(8'($urandom_range(255)));
            end else if (kind < 26) begin
               frame.push_back(cfg_shadow.escape_prefix);
            end
            queue_frame(frame);
         end else begin
            repeat ($urandom_range(1, 6)) begin
               queue_item(8'($urandom_range(255)), $urandom_range(99) < 30);
            end
         end
      end
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] value);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.payload <= '{index: idx, data: value};
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         REG_ESCAPE_PREFIX: cfg_shadow.escape_prefix = value;
         REG_CODE_FOR_FE:   cfg_shadow.code_for_fe = value;
         REG_CODE_FOR_FD:   cfg_shadow.code_for_fd = value;
         default: ;
      endcase
      csr_ch.valid <= 1'b0;
   endtask

   // Waits until every byte has been taken and every result has come back.
   task automatic wait_idle();
      do @(posedge clock);
      while (wire_bytes_queue.size() != 0 || req_ch.valid || expected_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [7:0] p;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      csr_ch.valid = 1'b0;
      csr_ch.payload = '0;
      rsp_ch.ready = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset register values; the sender idles lightly, the receiver heavily.
      send_idle_pct = 18;
      recv_idle_pct = 50;
      p = cfg_shadow.escape_prefix;
      queue_frame({8'h00});
      queue_frame({8'hFF, 8'hFF});
      queue_frame({p, cfg_shadow.code_for_fe, p, cfg_shadow.code_for_fd, 8'h03});
      queue_frame({8'h55});
      queue_frame({p, 8'h07, p, 8'h80, 8'h7F});
      queue_frame({p, 8'h07, p ^ 8'h07});
      queue_frame({8'h11, p, 8'h07});
      queue_frame({8'h01, p});
      queue_random_traffic(250);
      wait_idle();

      // Extreme register values and a write to the unused index.
      send_idle_pct = 50;
      recv_idle_pct = 18;
      write_csr(REG_ESCAPE_PREFIX, 8'h00);
      write_csr(REG_CODE_FOR_FE, 8'hFF);
      write_csr(REG_CODE_FOR_FD, 8'h80);
      write_csr(REG_UNUSED, 8'hA5);
      queue_frame({8'h00, 8'hFF, 8'h00, 8'h80, 8'h7F});
      queue_random_traffic(250);
      wait_idle();

      // Both codes equal: the escape must decode to 0xFE.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(REG_ESCAPE_PREFIX, 8'hFF);
      write_csr(REG_CODE_FOR_FE, 8'h00);
      write_csr(REG_CODE_FOR_FD, 8'h00);
      queue_frame({8'hFF, 8'h00});
      queue_random_traffic(200);
      wait_idle();

      // A code equal to the prefix, then a long frame that saturates the count under back-pressure.
      write_csr(REG_ESCAPE_PREFIX, 8'h7E);
      write_csr(REG_CODE_FOR_FE, 8'h7E);
      write_csr(REG_CODE_FOR_FD, 8'h5D);
      queue_frame({8'h7E, 8'h7E});
      queue_frame({8'h7E, 8'h5D, 8'h7E, 8'h7E, 8'h5D});
      queue_frame(clean_frame(290));
      hold_off_go = 1'b1;
      queue_random_traffic(100);
      wait_idle();

      if (error_count == 0) begin
         $display("byte_unstuff_xor_check_test passed");
      end else begin
         $display("byte_unstuff_xor_check_test failed");
      end
      $finish;
   end

endmodule

[files.f]
src/bux_pkg.sv
src/bux_stream_if.sv
src/bux_decoder.sv
src/byte_unstuff_xor_check.sv
src/bux_checker.sv
tb/sv/byte_unstuff_xor_check_test.sv
